// ===== rtl/core/pshp_pkg.sv =====
// Package for the packet size and delay shaper: constants, types and the control ROM.
package pshp_pkg;

  // Table geometry. The two table registers hold eight 16-bit entries.
  localparam int unsigned SIZE_SLOTS    = 8;
  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned MAX_ENTRIES   =
    (SIZE_SLOTS < TABLE_ENTRIES) ? SIZE_SLOTS : TABLE_ENTRIES;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam logic [3:0]  COUNT_CAP     = 4'(MAX_ENTRIES);

  // Generator constants.
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;

  // Register reset values.
  localparam logic [63:0] TABLE_LOW_RST  = 64'd144116287595872320;
  localparam logic [63:0] TABLE_HIGH_RST = 64'd6442534831104;
  localparam logic [3:0]  COUNT_RST      = 4'd7;

  // Divisors and offsets of the delay ranges, and the dummy draw threshold.
  localparam logic [9:0]  DIV_BASIC    = 10'd100;
  localparam logic [9:0]  DIV_ADVANCED = 10'd500;
  localparam logic [9:0]  DIV_MAXIMUM  = 10'd1000;
  localparam logic [9:0]  DIV_PERCENT  = 10'd100;
  localparam logic [10:0] OFF_BASIC    = 11'd10;
  localparam logic [10:0] OFF_ADVANCED = 11'd50;
  localparam logic [10:0] OFF_MAXIMUM  = 11'd100;
  localparam logic [9:0]  DUMMY_PCT    = 10'd15;

  // Dummy lengths.
  localparam logic [15:0] DUMMY_LEN_BASIC = 16'd64;
  localparam logic [15:0] DUMMY_LEN_ADV   = 16'd128;
  localparam logic [15:0] DUMMY_LEN_MAX   = 16'd256;

  typedef enum logic [1:0] {
    LVL_NONE,
    LVL_BASIC,
    LVL_ADVANCED,
    LVL_MAXIMUM
  } level_t;

  typedef enum logic [2:0] {
    REG_LEVEL,
    REG_DUMMY_ENABLE,
    REG_SEED,
    REG_TABLE_LOW,
    REG_TABLE_HIGH,
    REG_SIZE_COUNT
  } reg_idx_t;

  // Datapath operations of one control word.
  typedef enum logic [3:0] {
    OP_WAIT_IN,
    OP_SCAN,
    OP_DRAW,
    OP_MOD,
    OP_SET_REAL,
    OP_TEST,
    OP_DUMMY_LEN,
    OP_SET_DUMMY,
    OP_EMIT_REAL,
    OP_EMIT_DUMMY,
    OP_EMIT_LAST
  } op_t;

  typedef enum logic {
    DIV_LEVEL,
    DIV_PCT
  } div_sel_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NO_DUMMY,
    JMP_MISS
  } jmp_t;

  localparam int unsigned STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SCAN       = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DRAW_REAL  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MOD_REAL   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SET_REAL   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DRAW_PCT   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MOD_PCT    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_TEST       = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DUMMY_LEN  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DRAW_DUMMY = 4'd9;
  localparam logic [STEP_W-1:0] STEP_MOD_DUMMY  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_SET_DUMMY  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_EMIT_REAL  = 4'd12;
  localparam logic [STEP_W-1:0] STEP_EMIT_DUMMY = 4'd13;
  localparam logic [STEP_W-1:0] STEP_EMIT_LAST  = 4'd14;

  typedef struct packed {
    op_t               op;
    div_sel_t          div_sel;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Control program. A word whose jump condition holds goes to its target
  // once its operation is done; otherwise the step counter moves on by one.
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    w = '{OP_WAIT_IN, DIV_LEVEL, JMP_NONE, STEP_IDLE};
    unique case (step)
      STEP_IDLE:       w = '{OP_WAIT_IN,    DIV_LEVEL, JMP_NONE,     STEP_IDLE};
      STEP_SCAN:       w = '{OP_SCAN,       DIV_LEVEL, JMP_NONE,     STEP_IDLE};
      STEP_DRAW_REAL:  w = '{OP_DRAW,       DIV_LEVEL, JMP_NONE,     STEP_IDLE};
      STEP_MOD_REAL:   w = '{OP_MOD,        DIV_LEVEL, JMP_NONE,     STEP_IDLE};
      STEP_SET_REAL:   w = '{OP_SET_REAL,   DIV_LEVEL, JMP_NO_DUMMY, STEP_EMIT_LAST};
      STEP_DRAW_PCT:   w = '{OP_DRAW,       DIV_PCT,   JMP_NONE,     STEP_IDLE};
      STEP_MOD_PCT:    w = '{OP_MOD,        DIV_PCT,   JMP_NONE,     STEP_IDLE};
      STEP_TEST:       w = '{OP_TEST,       DIV_LEVEL, JMP_MISS,     STEP_EMIT_LAST};
      STEP_DUMMY_LEN:  w = '{OP_DUMMY_LEN,  DIV_LEVEL, JMP_NONE,     STEP_IDLE};
      STEP_DRAW_DUMMY: w = '{OP_DRAW,       DIV_LEVEL, JMP_NONE,     STEP_IDLE};
      STEP_MOD_DUMMY:  w = '{OP_MOD,        DIV_LEVEL, JMP_NONE,     STEP_IDLE};
      STEP_SET_DUMMY:  w = '{OP_SET_DUMMY,  DIV_LEVEL, JMP_NONE,     STEP_IDLE};
      STEP_EMIT_REAL:  w = '{OP_EMIT_REAL,  DIV_LEVEL, JMP_NONE,     STEP_IDLE};
      STEP_EMIT_DUMMY: w = '{OP_EMIT_DUMMY, DIV_LEVEL, JMP_ALWAYS,   STEP_IDLE};
      STEP_EMIT_LAST:  w = '{OP_EMIT_LAST,  DIV_LEVEL, JMP_ALWAYS,   STEP_IDLE};
      default:         w = '{OP_WAIT_IN,    DIV_LEVEL, JMP_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/packet_size_and_delay_shaper.sv =====
// Packet size and delay shaper: microcoded sequencer with its datapath and result register.
//
// Each item on the input channel is the length of one real packet. The block answers with
// one result for the real packet (its length snapped to the nearest entry of the size table,
// ties to the earlier entry, or kept as it is when the level is none or the table is empty,
// and a send delay) and, when dummy traffic is enabled and the level is not none, sometimes
// a second result that describes a dummy packet; the last flag marks the final result of
// each item. A 32-bit linear congruential generator supplies all random draws; writing the
// seed register reloads it. A short program in a control ROM steps through the work: the
// table scan visits one entry per cycle, or no entry when the level is none or the table
// is empty. A delay draw or the dummy decision draw passes through the generator multiplier
// and then through the remainder unit, which reduces the draw by 100, 500 or 1000 one hex
// digit per cycle; the dummy length draw needs only the multiplier. One draw is taken per
// real packet, one more to decide on a dummy, and two more when a dummy is sent. Each
// result is handed to the output register once that register is empty or being read.
// Results leave through that output register, so a waiting result does not hold up the
// next item.
// The configuration channel is always ready and must only be written while the block is idle.
module packet_size_and_delay_shaper (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_packet_length,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_length,
  output logic [10:0] out_delay_ms,
  output logic        out_is_dummy,
  output logic [7:0]  out_fill_base,
  output logic        out_last,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Configuration registers.
  pshp_pkg::level_t level_r;
  logic             dummy_en_r;
  logic [63:0]      tbl_low_r;
  logic [63:0]      tbl_high_r;
  logic [3:0]       count_r;

  // Sequencer.
  logic [pshp_pkg::STEP_W-1:0] step_r;
  logic [pshp_pkg::STEP_W-1:0] step_nxt;
  pshp_pkg::uword_t            uw;
  logic                        op_done;
  logic                        jmp_take;

  // Datapath registers.
  logic [31:0]              rng_r;
  logic [31:0]              rng_step;
  logic [15:0]              len_r;
  logic [15:0]              best_r;
  logic [16:0]              bestdiff_r;
  logic [pshp_pkg::IDX_W-1:0] idx_r;
  logic [31:0]              mod_src_r;
  logic [9:0]               rem_r;
  logic [9:0]               div_r;
  logic [2:0]               dig_r;
  logic [15:0]              real_len_r;
  logic [10:0]              real_dly_r;
  logic [15:0]              dum_len_r;
  logic [7:0]               dum_fill_r;
  logic [10:0]              dum_dly_r;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_length_r;
  logic [10:0] out_delay_r;
  logic        out_is_dummy_r;
  logic [7:0]  out_fill_r;
  logic        out_last_r;

  // Scan logic.
  logic [127:0] tbl_all;
  logic [15:0]  entry;
  logic [15:0]  diff;
  logic [3:0]   n_eff;
  logic         skip_scan;
  logic         scan_last;

  // Remainder unit.
  logic [13:0] rem_t;
  logic [13:0] rem_red;
  logic [13:0] mult;
  logic [9:0]  div_sel_val;
  logic [10:0] dly_off;
  logic [10:0] dly_val;
  logic        emit_ok;

  assign uw        = pshp_pkg::ucode(step_r);
  assign in_ready  = (uw.op == pshp_pkg::OP_WAIT_IN);
  assign cfg_ready = 1'b1;
  assign rng_step  = rng_r * pshp_pkg::LCG_MUL + pshp_pkg::LCG_INC;

  // Nearest-size scan, one table entry per cycle.
  assign tbl_all   = {tbl_high_r, tbl_low_r};
  assign entry     = tbl_all[{idx_r, 4'b0000} +: 16];
  assign diff      = (entry > len_r) ? (entry - len_r) : (len_r - entry);
  assign n_eff     = (count_r > pshp_pkg::COUNT_CAP) ? pshp_pkg::COUNT_CAP : count_r;
  assign skip_scan = (level_r == pshp_pkg::LVL_NONE) || (n_eff == 4'd0);
  assign scan_last = ({{(4 - pshp_pkg::IDX_W){1'b0}}, idx_r} == (n_eff - 4'd1));

  // One hex digit of the remainder: bring in the next digit, then take off the
  // largest multiple of the divisor that fits. The partial remainder stays
  // below the divisor, so fifteen multiples cover every case.
  assign rem_t = {rem_r, mod_src_r[31:28]};

  always_comb begin
    rem_red = rem_t;
    mult    = '0;
    for (int k = 1; k < 16; k++) begin
      mult = 14'(k) * {4'd0, div_r};
      if (rem_t >= mult) begin
        rem_red = rem_t - mult;
      end
    end
  end

  always_comb begin
    case (level_r)
      pshp_pkg::LVL_ADVANCED: div_sel_val = pshp_pkg::DIV_ADVANCED;
      pshp_pkg::LVL_MAXIMUM:  div_sel_val = pshp_pkg::DIV_MAXIMUM;
      default:                div_sel_val = pshp_pkg::DIV_BASIC;
    endcase
    if (uw.div_sel == pshp_pkg::DIV_PCT) begin
      div_sel_val = pshp_pkg::DIV_PERCENT;
    end
  end

  always_comb begin
    case (level_r)
      pshp_pkg::LVL_BASIC:    dly_off = pshp_pkg::OFF_BASIC;
      pshp_pkg::LVL_ADVANCED: dly_off = pshp_pkg::OFF_ADVANCED;
      pshp_pkg::LVL_MAXIMUM:  dly_off = pshp_pkg::OFF_MAXIMUM;
      default:                dly_off = 11'd0;
    endcase
    // At level none the delay is zero whatever the draw gave.
    dly_val = (level_r == pshp_pkg::LVL_NONE) ? 11'd0 : ({1'b0, rem_r} + dly_off);
  end

  // Sequencer: completion of the current word and the next step.
  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    case (uw.op)
      pshp_pkg::OP_WAIT_IN:    op_done = in_valid;
      pshp_pkg::OP_SCAN:       op_done = skip_scan || scan_last;
      pshp_pkg::OP_MOD:        op_done = (dig_r == 3'd7);
      pshp_pkg::OP_EMIT_REAL,
      pshp_pkg::OP_EMIT_DUMMY,
      pshp_pkg::OP_EMIT_LAST:  op_done = emit_ok;
      default:                 op_done = 1'b1;
    endcase
    case (uw.jmp)
      pshp_pkg::JMP_ALWAYS:   jmp_take = 1'b1;
      pshp_pkg::JMP_NO_DUMMY: jmp_take = !(dummy_en_r && (level_r != pshp_pkg::LVL_NONE));
      pshp_pkg::JMP_MISS:     jmp_take = (rem_r >= pshp_pkg::DUMMY_PCT);
      default:                jmp_take = 1'b0;
    endcase
    if (!op_done) begin
      step_nxt = step_r;
    end else if (jmp_take) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  // Control state: step counter, configuration, generator and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= pshp_pkg::STEP_IDLE;
      level_r     <= pshp_pkg::LVL_NONE;
      dummy_en_r  <= 1'b0;
      tbl_low_r   <= pshp_pkg::TABLE_LOW_RST;
      tbl_high_r  <= pshp_pkg::TABLE_HIGH_RST;
      count_r     <= pshp_pkg::COUNT_RST;
      rng_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (uw.op == pshp_pkg::OP_DRAW || uw.op == pshp_pkg::OP_DUMMY_LEN) begin
        rng_r <= rng_step;
      end
      if (cfg_valid) begin
        case (pshp_pkg::reg_idx_t'(cfg_index))
          pshp_pkg::REG_LEVEL:        level_r    <= pshp_pkg::level_t'(cfg_data[1:0]);
          pshp_pkg::REG_DUMMY_ENABLE: dummy_en_r <= cfg_data[0];
          pshp_pkg::REG_SEED:         rng_r      <= cfg_data[31:0];
          pshp_pkg::REG_TABLE_LOW:    tbl_low_r  <= cfg_data;
          pshp_pkg::REG_TABLE_HIGH:   tbl_high_r <= cfg_data;
          pshp_pkg::REG_SIZE_COUNT:   count_r    <= cfg_data[3:0];
          default: ;
        endcase
      end
      if ((uw.op == pshp_pkg::OP_EMIT_REAL || uw.op == pshp_pkg::OP_EMIT_DUMMY ||
           uw.op == pshp_pkg::OP_EMIT_LAST) && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath, driven by the operation of the current control word.
  always_ff @(posedge clk) begin
    case (uw.op)
      pshp_pkg::OP_WAIT_IN: begin
        len_r      <= in_packet_length;
        best_r     <= in_packet_length;
        bestdiff_r <= '1;
        idx_r      <= '0;
      end
      pshp_pkg::OP_SCAN: begin
        if (!skip_scan) begin
          if ({1'b0, diff} < bestdiff_r) begin
            bestdiff_r <= {1'b0, diff};
            best_r     <= entry;
          end
          idx_r <= idx_r + 1'b1;
        end
      end
      pshp_pkg::OP_DRAW: begin
        mod_src_r <= {1'b0, rng_step[30:0]};
        rem_r     <= '0;
        dig_r     <= '0;
        div_r     <= div_sel_val;
      end
      pshp_pkg::OP_MOD: begin
        rem_r     <= rem_red[9:0];
        mod_src_r <= {mod_src_r[27:0], 4'b0000};
        dig_r     <= dig_r + 3'd1;
      end
      pshp_pkg::OP_SET_REAL: begin
        real_len_r <= best_r;
        real_dly_r <= dly_val;
      end
      pshp_pkg::OP_DUMMY_LEN: begin
        dum_fill_r <= rng_step[7:0];
        case (level_r)
          pshp_pkg::LVL_ADVANCED: dum_len_r <= pshp_pkg::DUMMY_LEN_ADV + {9'd0, rng_step[6:0]};
          pshp_pkg::LVL_MAXIMUM:  dum_len_r <= pshp_pkg::DUMMY_LEN_MAX + {8'd0, rng_step[7:0]};
          default:                dum_len_r <= pshp_pkg::DUMMY_LEN_BASIC;
        endcase
      end
      pshp_pkg::OP_SET_DUMMY: begin
        dum_dly_r <= dly_val;
      end
      pshp_pkg::OP_EMIT_REAL,
      pshp_pkg::OP_EMIT_LAST: begin
        if (emit_ok) begin
          out_length_r   <= real_len_r;
          out_delay_r    <= real_dly_r;
          out_is_dummy_r <= 1'b0;
          out_fill_r     <= 8'd0;
          out_last_r     <= (uw.op == pshp_pkg::OP_EMIT_LAST);
        end
      end
      pshp_pkg::OP_EMIT_DUMMY: begin
        if (emit_ok) begin
          out_length_r   <= dum_len_r;
          out_delay_r    <= dum_dly_r;
          out_is_dummy_r <= 1'b1;
          out_fill_r     <= dum_fill_r;
          out_last_r     <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_length   = out_length_r;
  assign out_delay_ms = out_delay_r;
  assign out_is_dummy = out_is_dummy_r;
  assign out_fill_base = out_fill_r;
  assign out_last     = out_last_r;

  // An accepted item always moves the sequencer into the table scan.
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (step_r == pshp_pkg::STEP_SCAN))
    else $error("accepted item did not start the scan");

  // Whatever consumes the remainder sees a fully reduced value.
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == pshp_pkg::OP_SET_REAL || uw.op == pshp_pkg::OP_TEST ||
     uw.op == pshp_pkg::OP_SET_DUMMY) |-> (rem_r < div_r))
    else $error("remainder not below its divisor");

  // A dummy is always the final result of its item.
  a_dummy_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_dummy_r) |-> out_last_r)
    else $error("dummy result without last flag");

  // Handing over the dummy ends the program and returns to idle.
  a_dummy_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == pshp_pkg::OP_EMIT_DUMMY && op_done) |=>
      (step_r == pshp_pkg::STEP_IDLE && out_valid_r && out_is_dummy_r))
    else $error("sequencer did not finish after the dummy");

endmodule

// ===== tb/packet_size_and_delay_shaper_tb.sv =====
// Self-checking testbench for the packet size and delay shaper with its own behavioral predictor.
`timescale 1ns / 100ps

module packet_size_and_delay_shaper_tb;

  // Register indexes that the block does not decode. Writes to them must be ignored.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // Cycles to wait after the last result before the block is taken as idle. The wait is
  // longer than the longest item, so it covers any work still in flight.
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 115;

  // One result of the shaper as the predictor sees it.
  typedef struct packed {
    logic [15:0] length;
    logic [10:0] delay;
    logic        dummy;
    logic [7:0]  fill;
    logic        last;
  } shaped_pkt_t;

  // One row of the directed table: the settings it needs, the packet length and, where it
  // is obvious from the size table, the length that the real result must carry.
  typedef struct {
    pshp_pkg::level_t lvl;
    logic             dummy;
    logic [3:0]       count;
    logic [15:0]      len;
    logic             typed;
    logic [15:0]      want_len;
  } probe_row_t;

  localparam int unsigned PROBE_ROWS = 23;

  // With the reset table (64, 128, 256, 512, 1024, 1280, 1500, 0) most snapped lengths
  // can be read off directly. Rows cover ties, the unused eighth entry, an empty table,
  // counts beyond the table, level none with dummies enabled and every level.
  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{pshp_pkg::LVL_NONE,     1'b0, 4'd7,  16'd0,     1'b1, 16'd0},
    '{pshp_pkg::LVL_NONE,     1'b0, 4'd7,  16'd65535, 1'b1, 16'd65535},
    '{pshp_pkg::LVL_NONE,     1'b0, 4'd7,  16'd1000,  1'b1, 16'd1000},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd7,  16'd0,     1'b1, 16'd64},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd7,  16'd96,    1'b1, 16'd64},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd7,  16'd97,    1'b1, 16'd128},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd7,  16'd384,   1'b1, 16'd256},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd7,  16'd1390,  1'b1, 16'd1280},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd7,  16'd65535, 1'b1, 16'd1500},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd8,  16'd0,     1'b1, 16'd0},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd8,  16'd32,    1'b1, 16'd64},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd15, 16'd10,    1'b1, 16'd0},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd9,  16'd33,    1'b1, 16'd64},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd0,  16'd12345, 1'b1, 16'd12345},
    '{pshp_pkg::LVL_BASIC,    1'b0, 4'd1,  16'd65535, 1'b1, 16'd64},
    '{pshp_pkg::LVL_ADVANCED, 1'b1, 4'd7,  16'd700,   1'b1, 16'd512},
    '{pshp_pkg::LVL_ADVANCED, 1'b1, 4'd7,  16'd1200,  1'b0, 16'd0},
    '{pshp_pkg::LVL_MAXIMUM,  1'b1, 4'd7,  16'd2000,  1'b1, 16'd1500},
    '{pshp_pkg::LVL_MAXIMUM,  1'b1, 4'd7,  16'd300,   1'b0, 16'd0},
    '{pshp_pkg::LVL_BASIC,    1'b1, 4'd7,  16'd5000,  1'b1, 16'd1500},
    '{pshp_pkg::LVL_BASIC,    1'b1, 4'd7,  16'd600,   1'b0, 16'd0},
    '{pshp_pkg::LVL_NONE,     1'b1, 4'd7,  16'd1500,  1'b1, 16'd1500},
    '{pshp_pkg::LVL_NONE,     1'b1, 4'd0,  16'd77,    1'b1, 16'd77}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_packet_length;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_length;
  logic [10:0] out_delay_ms;
  logic        out_is_dummy;
  logic [7:0]  out_fill_base;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // Predictor copy of the registers and of the generator.
  pshp_pkg::level_t cur_lvl;
  logic             dummy_on;
  logic [31:0]      gen_state;
  logic [63:0]      tab_low;
  logic [63:0]      tab_high;
  logic [3:0]       tab_count;

  // Results still owed by the block, oldest first.
  shaped_pkt_t shaped_fifo [$];
  int unsigned fault_count;
  // When clear, neither side inserts gaps or stalls.
  logic        gaps_on;
  int unsigned stall_left;

  packet_size_and_delay_shaper dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_packet_length (in_packet_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_length       (out_length),
    .out_delay_ms     (out_delay_ms),
    .out_is_dummy     (out_is_dummy),
    .out_fill_base    (out_fill_base),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The limit allows for every item producing a dummy, long sender gaps and long receiver
  // stalls on both results, several times over.
  initial begin
    #10_000_000;
    $display("packet_size_and_delay_shaper verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------------------

  // Advances the generator once and returns the 31-bit draw.
  function automatic logic [31:0] roll_lcg();
    gen_state = gen_state * pshp_pkg::LCG_MUL + pshp_pkg::LCG_INC;
    return {1'b0, gen_state[30:0]};
  endfunction

  // Every delay costs one draw, even at level none where the delay itself is zero.
  function automatic logic [10:0] draw_delay();
    int unsigned r;
    r = roll_lcg();
    case (cur_lvl)
      pshp_pkg::LVL_BASIC:    return 11'(r % 100 + 10);
      pshp_pkg::LVL_ADVANCED: return 11'(r % 500 + 50);
      pshp_pkg::LVL_MAXIMUM:  return 11'(r % 1000 + 100);
      default:                return 11'd0;
    endcase
  endfunction

  function automatic logic [15:0] entry_at(int unsigned i);
    logic [63:0] w;
    w = (i < 4) ? tab_low : tab_high;
    return w[(i % 4) * 16 +: 16];
  endfunction

  // Nearest table entry; a strict compare keeps the earlier entry on a tie.
  function automatic logic [15:0] snap_length(logic [15:0] len);
    int unsigned n;
    int unsigned best;
    int unsigned best_d;
    int unsigned e;
    int unsigned d;
    n = tab_count;
    if (n > pshp_pkg::SIZE_SLOTS) n = pshp_pkg::SIZE_SLOTS;
    if (n > 8) n = 8;
    if (n == 0) return len;
    best = entry_at(0);
    best_d = (best > len) ? best - len : len - best;
    for (int unsigned i = 1; i < n; i++) begin
      e = entry_at(i);
      d = (e > len) ? e - len : len - e;
      if (d < best_d) begin
        best_d = d;
        best = e;
      end
    end
    return 16'(best);
  endfunction

  // Works out the results of one packet and returns how many there are.
  function automatic int unsigned shape_packet(input logic [15:0] len,
                                               output shaped_pkt_t pkt_main,
                                               output shaped_pkt_t pkt_extra);
    int unsigned r;
    int unsigned r2;
    int unsigned n;
    n = 1;
    pkt_extra = '0;
    pkt_main.length = (cur_lvl != pshp_pkg::LVL_NONE) ? snap_length(len) : len;
    pkt_main.delay  = draw_delay();
    pkt_main.dummy  = 1'b0;
    pkt_main.fill   = 8'd0;
    pkt_main.last   = 1'b1;
    if (dummy_on && cur_lvl != pshp_pkg::LVL_NONE) begin
      r = roll_lcg();
      if (r % 100 < 15) begin
        // The length draw comes first, then the dummy's own delay draw.
        r2 = roll_lcg();
        case (cur_lvl)
          pshp_pkg::LVL_ADVANCED: pkt_extra.length = 16'(128 + r2 % 128);
          pshp_pkg::LVL_MAXIMUM:  pkt_extra.length = 16'(256 + r2 % 256);
          default:                pkt_extra.length = 16'd64;
        endcase
        pkt_extra.delay = draw_delay();
        pkt_extra.dummy = 1'b1;
        pkt_extra.fill  = r2[7:0];
        pkt_extra.last  = 1'b1;
        pkt_main.last   = 1'b0;
        n = 2;
      end
    end
    return n;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      pshp_pkg::REG_LEVEL:        cur_lvl = pshp_pkg::level_t'(val[1:0]);
      pshp_pkg::REG_DUMMY_ENABLE: dummy_on = val[0];
      pshp_pkg::REG_SEED:         gen_state = val[31:0];
      pshp_pkg::REG_TABLE_LOW:    tab_low = val;
      pshp_pkg::REG_TABLE_HIGH:   tab_high = val;
      pshp_pkg::REG_SIZE_COUNT:   tab_count = val[3:0];
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Random choices.
  // ---------------------------------------------------------------------------------------

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Table words mix extremes, repeated entries (to force ties) and typical packet sizes.
  function automatic logic [63:0] random_table_word();
    logic [63:0] w;
    logic [15:0] e;
    e = 16'd0;
    for (int unsigned i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0:       e = 16'hffff;
        1:       e = 16'd0;
        2:       e = e;
        3:       e = 16'($urandom_range(40, 1600));
        default: e = 16'($urandom_range(0, 65535));
      endcase
      w[i * 16 +: 16] = e;
    end
    return w;
  endfunction

  // Lengths cluster around the table entries so that ties and near misses are common.
  function automatic logic [15:0] pick_length();
    int v;
    case ($urandom_range(0, 9))
      0:          return 16'd0;
      1:          return 16'hffff;
      2, 3, 4:    return 16'($urandom_range(0, 65535));
      5, 6, 7: begin
        v = int'(entry_at($urandom_range(0, 7))) + int'($urandom_range(0, 80)) - 40;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
      end
      default:    return 16'($urandom_range(0, 2000));
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving.
  // ---------------------------------------------------------------------------------------

  // Offers one packet length and records its results once it is taken. The valid is left
  // high after acceptance so that a zero gap keeps it high into the next item.
  task automatic push_length(input logic [15:0] len, input logic typed,
                             input logic [15:0] want_len);
    int unsigned gap;
    int unsigned n;
    shaped_pkt_t pkt_main;
    shaped_pkt_t pkt_extra;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packet_length <= len;
    do @(posedge clk); while (!in_ready);
    n = shape_packet(len, pkt_main, pkt_extra);
    if (typed) pkt_main.length = want_len;
    shaped_fifo.push_back(pkt_main);
    if (n == 2) shaped_fifo.push_back(pkt_extra);
  endtask

  // Drops the input valid, waits for every owed result and lets the block run dry.
  task automatic settle();
    in_valid <= 1'b0;
    while (shaped_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the valid drops for a cycle before the next write.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // The receiver stalls in random bursts while gaps are on and is always ready otherwise.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  // Values are sampled at the edge, before any update that the edge itself causes.
  always @(posedge clk) begin : result_monitor
    shaped_pkt_t want;
    if (rst_n && out_valid && out_ready) begin
      if (shaped_fifo.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual length %0d dummy %0d",
                 $time, out_length, out_is_dummy);
        fault_count++;
      end else begin
        want = shaped_fifo.pop_front();
        check_field("length", want.length, out_length);
        check_field("delay_ms", 16'(want.delay), 16'(out_delay_ms));
        check_field("is_dummy", 16'(want.dummy), 16'(out_is_dummy));
        check_field("fill_base", 16'(want.fill), 16'(out_fill_base));
        check_field("last", 16'(want.last), 16'(out_last));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------------------

  initial begin : stimulus
    logic [63:0]      word;
    pshp_pkg::level_t lvl;
    logic [3:0]       count;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_packet_length <= 16'd0;
    out_ready        <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= pshp_pkg::REG_LEVEL;
    cfg_data         <= 64'd0;
    stall_left       = 0;
    fault_count      = 0;
    gaps_on          = 1'b1;

    // Predictor state after reset; the generator starts from the reset seed of zero.
    cur_lvl   = pshp_pkg::LVL_NONE;
    dummy_on  = 1'b0;
    gen_state = 32'd0;
    tab_low   = pshp_pkg::TABLE_LOW_RST;
    tab_high  = pshp_pkg::TABLE_HIGH_RST;
    tab_count = pshp_pkg::COUNT_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A row whose settings differ from the current ones first lets the
    // block go idle and rewrites the registers that changed.
    for (int unsigned i = 0; i < PROBE_ROWS; i++) begin
      if (probe_rows[i].lvl != cur_lvl || probe_rows[i].dummy != dummy_on ||
          probe_rows[i].count != tab_count) begin
        settle();
        if (probe_rows[i].lvl != cur_lvl)
          write_reg(pshp_pkg::REG_LEVEL, 64'(probe_rows[i].lvl));
        if (probe_rows[i].dummy != dummy_on)
          write_reg(pshp_pkg::REG_DUMMY_ENABLE, 64'(probe_rows[i].dummy));
        if (probe_rows[i].count != tab_count)
          write_reg(pshp_pkg::REG_SIZE_COUNT, 64'(probe_rows[i].count));
      end
      push_length(probe_rows[i].len, probe_rows[i].typed, probe_rows[i].want_len);
    end

    // Random part. The phases walk all levels in turn, mostly with dummies enabled, and each
    // loads fresh tables. Upper data bits are junk to check that narrow registers mask
    // them. Every third phase runs with no gaps or stalls at all.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      gaps_on = (p % 3 != 2);
      lvl = pshp_pkg::level_t'(2'(p % 4));

      word = {$urandom, $urandom};
      word[1:0] = lvl;
      write_reg(pshp_pkg::REG_LEVEL, word);

      word = {$urandom, $urandom};
      word[0] = ($urandom_range(0, 4) != 0);
      write_reg(pshp_pkg::REG_DUMMY_ENABLE, word);

      // Seed extremes first, then a reload on about half the phases.
      if (p == 0) begin
        write_reg(pshp_pkg::REG_SEED, {$urandom, 32'hffffffff});
      end else if (p == 1) begin
        write_reg(pshp_pkg::REG_SEED, {$urandom, 32'h0});
      end else if ($urandom_range(0, 1) == 0) begin
        write_reg(pshp_pkg::REG_SEED, {$urandom, $urandom});
      end

      write_reg(pshp_pkg::REG_TABLE_LOW, random_table_word());
      write_reg(pshp_pkg::REG_TABLE_HIGH, random_table_word());
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});

      // An empty table, a count beyond the table and a full table each get a phase.
      if (p == 2) count = 4'd0;
      else if (p == 3) count = 4'd15;
      else if (p == 4) count = 4'd8;
      else if ($urandom_range(0, 5) == 0) count = 4'($urandom_range(9, 15));
      else count = 4'($urandom_range(0, 8));
      word = {$urandom, $urandom};
      word[3:0] = count;
      write_reg(pshp_pkg::REG_SIZE_COUNT, word);

      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        push_length(pick_length(), 1'b0, 16'd0);
      end
    end

    settle();

    if (fault_count == 0 && shaped_fifo.size() == 0) begin
      $display("packet_size_and_delay_shaper verification clean");
    end else begin
      $display("packet_size_and_delay_shaper verification failed");
    end
    $finish;
  end

endmodule
